// File: rtl/core/linked_list_queue_manager_top_macros.svh
// assertion macros shared by the queue manager rtl
`ifndef LINKED_LIST_QUEUE_MANAGER_TOP_MACROS_SVH
`define LINKED_LIST_QUEUE_MANAGER_TOP_MACROS_SVH

// checked on every clock edge outside of reset
`define LLQM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define LLQM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/llqm_pkg.sv
// shared constants and codes of the linked list queue manager
package llqm_pkg;

  localparam int unsigned QueueCountDef = 4;
  localparam int unsigned SlotCountDef  = 16;

  localparam int unsigned KindW     = 2;
  localparam int unsigned QueueIdxW = 2;
  localparam int unsigned SlotW     = 4;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH    = 2'd0,
    KIND_DEQUEUE = 2'd1,
    KIND_REMOVE  = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  // what an accepted word turns into once the queue state is known
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_EMPTY = 3'd1,
    OP_PUSH_TAIL  = 3'd2,
    OP_DEQUEUE    = 3'd3,
    OP_REMOVE     = 3'd4
  } op_e;

endpackage

// File: rtl/core/llqm_ram.sv
// generic ram, one write port and one read port with registered read data
module llqm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/linked_list_queue_manager_top.sv
// linked list queue manager: several fifo queues over one shared pool of slots
//
// input channel (in_valid_i / in_ready_o) takes one word: kind_i, queue_index_i,
// slot_i. kind push appends slot_i at the tail, dequeue takes the head off,
// remove unlinks slot_i and reports the slot that followed it.
// output channel (out_valid_o / out_ready_i) gives one word per input word:
// result_slot_o, result_valid_o, queue_empty_o, error_o.
// the queues are doubly linked lists in a next ram and a prev ram; the head
// and tail of queue q sit in the extra entry SlotCount+q of the next and prev
// ram. each ram has one read port with registered read data, so the
// dependent link reads and the two write states set the timing.
// states from accept to the result loaded into the output register: write2
// alone for an invalid or no-op word, write1 and write2 for push to an empty
// queue, read1, write1, write2 for push to a non-empty queue, and read1, read2,
// write1, write2 for dequeue and remove. a new word is taken only in idle.
// reset clears the control state and the per-queue non-empty flags; the rams
// hold no reset value and need no clearing pass. a stalled receiver holds the
// block in its last step with in_ready_o low until the pending result word is taken.
`include "linked_list_queue_manager_top_macros.svh"

module linked_list_queue_manager_top #(
  parameter int unsigned QueueCount = llqm_pkg::QueueCountDef,
  parameter int unsigned SlotCount  = llqm_pkg::SlotCountDef,
  localparam int unsigned QW = (QueueCount > 1) ? $clog2(QueueCount) : 1,
  localparam int unsigned SW = (SlotCount > 1) ? $clog2(SlotCount) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [llqm_pkg::KindW-1:0] kind_i,
  input  logic [QW-1:0]              queue_index_i,
  input  logic [SW-1:0]              slot_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [SW-1:0]              result_slot_o,
  output logic                       result_valid_o,
  output logic                       queue_empty_o,
  output logic                       error_o
);

  localparam int unsigned LW       = $clog2(SlotCount + 1);
  localparam int unsigned RamDepth = SlotCount + QueueCount;
  localparam int unsigned RW       = $clog2(RamDepth);

  localparam logic [LW-1:0] LinkNil  = LW'(SlotCount);
  localparam logic [RW-1:0] SentBase = RW'(SlotCount);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ1  = 5'b00010,
    ST_READ2  = 5'b00100,
    ST_WRITE1 = 5'b01000,
    ST_WRITE2 = 5'b10000
  } state_e;

  function automatic logic is_slot(logic [LW-1:0] v);
    return 32'(v) < SlotCount;
  endfunction

  state_e state_q, state_d;

  logic [QueueCount-1:0] nonempty_q;

  llqm_pkg::op_e op_q, op_dec;
  logic          err_q, err_dec;
  logic          q_ok_q;
  logic [QW-1:0] q_idx_q;
  logic [SW-1:0] s_q;
  logic [LW-1:0] lnk_a_q, lnk_b_q, head_q, tail_q;

  logic out_valid_q;
  logic [SW-1:0] res_slot_q;
  logic res_valid_q, res_empty_q, res_err_q;

  logic          accept, out_free, advance, push_fin;
  logic          q_ok_in, s_ok_in, ne_in;
  logic [QW-1:0] q_idx_in;
  logic [RW-1:0] hq_in, hq_q, s_addr;
  logic [LW-1:0] s_link;

  logic          next_we, prev_we;
  logic [RW-1:0] next_waddr, prev_waddr, next_raddr, prev_raddr;
  logic [LW-1:0] next_wdata, prev_wdata, next_rdata, prev_rdata;

  logic at_head, at_tail, ne_clear, ne_set, ne_after;
  logic fin_valid;
  logic [LW-1:0] fin_slot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = (state_q == ST_WRITE2) && out_free;
  assign push_fin   = advance && ((op_q == llqm_pkg::OP_PUSH_EMPTY) ||
                                  (op_q == llqm_pkg::OP_PUSH_TAIL));

  // decode of the incoming word against the current queue flags
  assign q_ok_in  = 32'(queue_index_i) < QueueCount;
  assign s_ok_in  = 32'(slot_i) < SlotCount;
  assign q_idx_in = queue_index_i;
  assign ne_in    = q_ok_in && nonempty_q[q_idx_in];
  assign hq_in    = SentBase + RW'(queue_index_i);

  always_comb begin
    op_dec  = llqm_pkg::OP_NONE;
    err_dec = 1'b0;
    unique case (llqm_pkg::kind_e'(kind_i))
      llqm_pkg::KIND_PUSH: begin
        if (q_ok_in && s_ok_in) begin
          op_dec = ne_in ? llqm_pkg::OP_PUSH_TAIL : llqm_pkg::OP_PUSH_EMPTY;
        end
      end
      llqm_pkg::KIND_DEQUEUE: begin
        if (q_ok_in) begin
          if (ne_in) begin
            op_dec = llqm_pkg::OP_DEQUEUE;
          end else begin
            err_dec = 1'b1;
          end
        end
      end
      llqm_pkg::KIND_REMOVE: begin
        if (q_ok_in && s_ok_in && ne_in) begin
          op_dec = llqm_pkg::OP_REMOVE;
        end
      end
      default: begin
        op_dec = llqm_pkg::OP_NONE;
      end
    endcase
  end

  assign hq_q   = SentBase + RW'(q_idx_q);
  assign s_addr = RW'(s_q);
  assign s_link = LW'(s_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_dec) inside
            llqm_pkg::OP_PUSH_EMPTY: state_d = ST_WRITE1;
            llqm_pkg::OP_PUSH_TAIL,
            llqm_pkg::OP_DEQUEUE,
            llqm_pkg::OP_REMOVE:     state_d = ST_READ1;
            default:                 state_d = ST_WRITE2;
          endcase
        end
      end
      ST_READ1: begin
        state_d = (op_q == llqm_pkg::OP_PUSH_TAIL) ? ST_WRITE1 : ST_READ2;
      end
      ST_READ2:  state_d = ST_WRITE1;
      ST_WRITE1: state_d = ST_WRITE2;
      ST_WRITE2: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // read addresses: first the entry named by the word, then the one it points to (dequeue) or the queue entry (remove)
  always_comb begin
    next_raddr = hq_q;
    prev_raddr = hq_q;
    if (state_q == ST_IDLE) begin
      if (llqm_pkg::kind_e'(kind_i) == llqm_pkg::KIND_REMOVE) begin
        next_raddr = RW'(slot_i);
        prev_raddr = RW'(slot_i);
      end else begin
        next_raddr = hq_in;
        prev_raddr = hq_in;
      end
    end else if (state_q == ST_READ1) begin
      if (op_q == llqm_pkg::OP_DEQUEUE) begin
        next_raddr = RW'(next_rdata);
      end
    end
  end

  assign at_head = (head_q == s_link);
  assign at_tail = (tail_q == s_link);

  always_comb begin
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_waddr = s_addr;
    prev_waddr = s_addr;
    next_wdata = LinkNil;
    prev_wdata = LinkNil;
    if (state_q == ST_WRITE1) begin
      case (op_q)
        llqm_pkg::OP_PUSH_EMPTY: begin
          next_we    = 1'b1;
          next_waddr = hq_q;
          next_wdata = s_link;
          prev_we    = 1'b1;
          prev_waddr = hq_q;
          prev_wdata = s_link;
        end
        llqm_pkg::OP_PUSH_TAIL: begin
          // old tail in lnk_b_q
          next_we    = is_slot(lnk_b_q);
          next_waddr = RW'(lnk_b_q);
          next_wdata = s_link;
          prev_we    = 1'b1;
          prev_wdata = lnk_b_q;
        end
        llqm_pkg::OP_DEQUEUE: begin
          // successor of the head in lnk_b_q
          next_we    = is_slot(lnk_b_q);
          next_waddr = hq_q;
          next_wdata = lnk_b_q;
          prev_we    = is_slot(lnk_b_q);
          prev_waddr = RW'(lnk_b_q);
        end
        llqm_pkg::OP_REMOVE: begin
          // successor in lnk_a_q, predecessor in lnk_b_q
          if (at_head && at_tail) begin
            next_we = 1'b0;
          end else if (at_head) begin
            next_we    = is_slot(lnk_a_q);
            next_waddr = hq_q;
            next_wdata = lnk_a_q;
            prev_we    = is_slot(lnk_a_q);
            prev_waddr = RW'(lnk_a_q);
          end else if (at_tail) begin
            prev_we    = is_slot(lnk_b_q);
            prev_waddr = hq_q;
            prev_wdata = lnk_b_q;
            next_we    = is_slot(lnk_b_q);
            next_waddr = RW'(lnk_b_q);
          end else begin
            next_we    = is_slot(lnk_b_q);
            next_waddr = RW'(lnk_b_q);
            next_wdata = lnk_a_q;
            prev_we    = is_slot(lnk_a_q);
            prev_waddr = RW'(lnk_a_q);
            prev_wdata = lnk_b_q;
          end
        end
        default: begin
          next_we = 1'b0;
        end
      endcase
    end else if (advance) begin
      // the unlinked or new slot gets its own links last
      case (op_q) inside
        llqm_pkg::OP_PUSH_EMPTY,
        llqm_pkg::OP_REMOVE: begin
          next_we = 1'b1;
          prev_we = 1'b1;
        end
        llqm_pkg::OP_PUSH_TAIL: begin
          next_we    = 1'b1;
          prev_we    = 1'b1;
          prev_waddr = hq_q;
          prev_wdata = s_link;
        end
        llqm_pkg::OP_DEQUEUE: begin
          next_we    = is_slot(lnk_a_q);
          next_waddr = RW'(lnk_a_q);
          prev_we    = is_slot(lnk_a_q);
          prev_waddr = RW'(lnk_a_q);
        end
        default: begin
          next_we = 1'b0;
        end
      endcase
    end
  end

  // queue flag and result word of the finishing item
  always_comb begin
    ne_set    = 1'b0;
    ne_clear  = 1'b0;
    fin_valid = 1'b0;
    fin_slot  = lnk_a_q;
    case (op_q) inside
      llqm_pkg::OP_PUSH_EMPTY,
      llqm_pkg::OP_PUSH_TAIL: begin
        ne_set = 1'b1;
      end
      llqm_pkg::OP_DEQUEUE: begin
        ne_clear  = (lnk_b_q == LinkNil);
        fin_valid = is_slot(lnk_a_q);
      end
      llqm_pkg::OP_REMOVE: begin
        ne_clear  = (at_head && at_tail) || (at_head && (lnk_a_q == LinkNil))
                    || (at_tail && (lnk_b_q == LinkNil));
        fin_valid = (lnk_a_q != LinkNil);
      end
      default: begin
        ne_set = 1'b0;
      end
    endcase
  end

  assign ne_after = q_ok_q && ((nonempty_q[q_idx_q] && !ne_clear) || ne_set);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (advance && q_ok_q) begin
        nonempty_q[q_idx_q] <= ne_after;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_dec;
      err_q   <= err_dec;
      q_ok_q  <= q_ok_in;
      q_idx_q <= q_idx_in;
      s_q     <= slot_i;
    end
    if (state_q == ST_READ1) begin
      lnk_a_q <= next_rdata;
      lnk_b_q <= prev_rdata;
    end
    if (state_q == ST_READ2) begin
      if (op_q == llqm_pkg::OP_DEQUEUE) begin
        // a head outside the pool has no successor
        lnk_b_q <= is_slot(lnk_a_q) ? next_rdata : LinkNil;
      end else begin
        head_q <= next_rdata;
        tail_q <= prev_rdata;
      end
    end
    if (advance) begin
      res_slot_q  <= fin_valid ? SW'(fin_slot) : '0;
      res_valid_q <= fin_valid;
      res_empty_q <= !ne_after;
      res_err_q   <= err_q;
    end
  end

  llqm_ram #(
    .Width (LW),
    .Depth (RamDepth)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  llqm_ram #(
    .Width (LW),
    .Depth (RamDepth)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign result_slot_o  = res_slot_q;
  assign result_valid_o = res_valid_q;
  assign queue_empty_o  = res_empty_q;
  assign error_o        = res_err_q;

  `LLQM_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == ST_IDLE) && !out_valid_q, "not idle in reset")
  `LLQM_ASSERT(a_accept_leaves_idle, accept |=> (state_q != ST_IDLE), "accepted word did not start")
  `LLQM_ASSERT(a_no_write_idle, (state_q == ST_IDLE) |-> !(next_we || prev_we), "ram write while idle")
  `LLQM_ASSERT(a_push_marks_queue, push_fin |=> nonempty_q[q_idx_q], "push left queue empty")
  `LLQM_ASSERT(a_error_word, out_valid_o && error_o |-> !result_valid_o && queue_empty_o, "error word carries a slot")

endmodule

// File: test/linked_list_queue_manager_top_tb.sv
// testbench of the linked list queue manager: directed table, then random list traffic
`timescale 1ns / 100ps

module linked_list_queue_manager_top_tb;
  import llqm_pkg::*;

  localparam int QueueCount  = QueueCountDef;
  localparam int SlotCount   = SlotCountDef;
  localparam int PhaseWords  = 300;
  localparam int PhaseCount  = 4;
  localparam int CycleLimit  = 300000;
  localparam int SettleWait  = 20;
  localparam logic [4:0] LinkNil = 5'(SlotCount);

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             valid;
    logic             empty;
    logic             err;
  } list_result_t;

  typedef struct {
    kind_e                kind;
    logic [QueueIdxW-1:0] queue;
    logic [SlotW-1:0]     slot;
    bit                   typed;
    list_result_t         res;
  } stim_row_t;

  localparam list_result_t DequeueEmptyRes = '{4'd0, 1'b0, 1'b1, 1'b1};
  localparam list_result_t EmptyQueueRes   = '{4'd0, 1'b0, 1'b1, 1'b0};
  localparam list_result_t PushRes         = '{4'd0, 1'b0, 1'b0, 1'b0};
  localparam list_result_t Untyped         = '{4'd0, 1'b0, 1'b0, 1'b0};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [KindW-1:0]     kind_i;
  logic [QueueIdxW-1:0] queue_index_i;
  logic [SlotW-1:0]     slot_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [SlotW-1:0]     result_slot_o;
  logic                 result_valid_o;
  logic                 queue_empty_o;
  logic                 error_o;

  // predicted list state
  logic       lst_nonempty [QueueCount];
  logic [4:0] lst_head     [QueueCount];
  logic [4:0] lst_tail     [QueueCount];
  logic [4:0] lst_next     [SlotCount];
  logic [4:0] lst_prev     [SlotCount];
  bit         lst_written  [SlotCount];

  list_result_t list_results_q [$];
  int fail_count = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;

  stim_row_t directed_rows [24] = '{
    '{KIND_DEQUEUE, 2'd0, 4'd0,  1'b1, DequeueEmptyRes},
    '{KIND_NOP,     2'd3, 4'd15, 1'b1, EmptyQueueRes},
    '{KIND_REMOVE,  2'd1, 4'd5,  1'b1, EmptyQueueRes},
    '{KIND_PUSH,    2'd0, 4'd0,  1'b1, PushRes},
    '{KIND_PUSH,    2'd0, 4'd15, 1'b1, PushRes},
    '{KIND_PUSH,    2'd0, 4'd7,  1'b1, PushRes},
    '{KIND_REMOVE,  2'd0, 4'd15, 1'b0, Untyped},
    '{KIND_DEQUEUE, 2'd0, 4'd0,  1'b0, Untyped},
    '{KIND_DEQUEUE, 2'd0, 4'd0,  1'b0, Untyped},
    '{KIND_DEQUEUE, 2'd0, 4'd0,  1'b1, DequeueEmptyRes},
    '{KIND_PUSH,    2'd3, 4'd15, 1'b1, PushRes},
    '{KIND_PUSH,    2'd3, 4'd8,  1'b0, Untyped},
    '{KIND_PUSH,    2'd3, 4'd1,  1'b0, Untyped},
    '{KIND_REMOVE,  2'd3, 4'd1,  1'b0, Untyped},
    '{KIND_REMOVE,  2'd3, 4'd15, 1'b0, Untyped},
    '{KIND_REMOVE,  2'd3, 4'd8,  1'b0, Untyped},
    '{KIND_PUSH,    2'd2, 4'd10, 1'b0, Untyped},
    '{KIND_PUSH,    2'd1, 4'd5,  1'b0, Untyped},
    '{KIND_PUSH,    2'd2, 4'd5,  1'b0, Untyped},
    '{KIND_DEQUEUE, 2'd1, 4'd0,  1'b0, Untyped},
    '{KIND_REMOVE,  2'd2, 4'd0,  1'b0, Untyped},
    '{KIND_DEQUEUE, 2'd2, 4'd3,  1'b0, Untyped},
    '{KIND_DEQUEUE, 2'd2, 4'd0,  1'b0, Untyped},
    '{KIND_NOP,     2'd0, 4'd0,  1'b0, Untyped}
  };

  linked_list_queue_manager_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .queue_index_i (queue_index_i),
    .slot_i        (slot_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_slot_o (result_slot_o),
    .result_valid_o(result_valid_o),
    .queue_empty_o (queue_empty_o),
    .error_o       (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // applies one word to the predicted lists and returns the result word it gives
  function automatic list_result_t apply_list_op(input kind_e kind,
                                                 input logic [QueueIdxW-1:0] q,
                                                 input logic [SlotW-1:0] s);
    list_result_t r;
    logic [4:0] h, n, p, t;
    logic       at_head, at_tail;
    r = '0;
    r.empty = 1'b1;
    if (int'(q) < QueueCount) begin
      case (kind)
        KIND_PUSH: begin
          lst_written[s] = 1'b1;
          if (!lst_nonempty[q]) begin
            lst_head[q]     = {1'b0, s};
            lst_tail[q]     = {1'b0, s};
            lst_next[s]     = LinkNil;
            lst_prev[s]     = LinkNil;
            lst_nonempty[q] = 1'b1;
          end else begin
            t = lst_tail[q];
            if (t < LinkNil) lst_next[t[3:0]] = {1'b0, s};
            lst_next[s] = LinkNil;
            lst_prev[s] = t;
            lst_tail[q] = {1'b0, s};
          end
        end
        KIND_DEQUEUE: begin
          if (!lst_nonempty[q]) begin
            r.err = 1'b1;
          end else begin
            h = lst_head[q];
            n = (h < LinkNil) ? lst_next[h[3:0]] : LinkNil;
            if (n == LinkNil) begin
              lst_nonempty[q] = 1'b0;
            end else begin
              lst_head[q] = n;
              if (n < LinkNil) lst_prev[n[3:0]] = LinkNil;
            end
            if (h < LinkNil) begin
              lst_prev[h[3:0]] = LinkNil;
              lst_next[h[3:0]] = LinkNil;
              r.slot  = h[3:0];
              r.valid = 1'b1;
            end
          end
        end
        KIND_REMOVE: begin
          if (lst_nonempty[q]) begin
            n       = lst_next[s];
            p       = lst_prev[s];
            at_head = ({1'b0, s} == lst_head[q]);
            at_tail = ({1'b0, s} == lst_tail[q]);
            if (at_head && at_tail) begin
              lst_nonempty[q] = 1'b0;
            end else if (at_head) begin
              if (n == LinkNil) begin
                lst_nonempty[q] = 1'b0;
              end else begin
                lst_head[q] = n;
                if (n < LinkNil) lst_prev[n[3:0]] = LinkNil;
              end
            end else if (at_tail) begin
              if (p == LinkNil) begin
                lst_nonempty[q] = 1'b0;
              end else begin
                lst_tail[q] = p;
                if (p < LinkNil) lst_next[p[3:0]] = LinkNil;
              end
            end else begin
              // middle unlink; writes aimed at the null mark are dropped
              if (p < LinkNil) lst_next[p[3:0]] = n;
              if (n < LinkNil) lst_prev[n[3:0]] = p;
            end
            lst_next[s] = LinkNil;
            lst_prev[s] = LinkNil;
            if (n != LinkNil) begin
              r.slot  = n[3:0];
              r.valid = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.empty = !lst_nonempty[q];
    end
    return r;
  endfunction

  task automatic send_word(input kind_e kind, input logic [QueueIdxW-1:0] q,
                           input logic [SlotW-1:0] s, input bit typed,
                           input list_result_t typed_res);
    list_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    queue_index_i <= q;
    slot_i        <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = apply_list_op(kind, q, s);
    list_results_q.push_back(typed ? typed_res : r);
  endtask

  // result side: check each taken word, then pick the next ready level
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (list_results_q.size() == 0) begin
          report_mismatch("result word with no word outstanding");
        end else begin
          want = list_results_q.pop_front();
          if (result_slot_o !== want.slot)
            report_mismatch($sformatf("result_slot got %0d want %0d", result_slot_o,
                                      want.slot));
          if (result_valid_o !== want.valid)
            report_mismatch($sformatf("result_valid got %b want %b", result_valid_o,
                                      want.valid));
          if (queue_empty_o !== want.empty)
            report_mismatch($sformatf("queue_empty got %b want %b", queue_empty_o,
                                      want.empty));
          if (error_o !== want.err)
            report_mismatch($sformatf("error got %b want %b", error_o, want.err));
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end else begin
      out_ready_i <= 1'b0;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int         owner [SlotCount];
    int         members [QueueCount][$];
    int         free_slots [$];
    int         empty_qs [$];
    int         busy_qs [$];
    int         cur, steps, r, pick;
    kind_e      kind;
    logic [QueueIdxW-1:0] qsel;
    logic [SlotW-1:0]     ssel;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_NOP;
    queue_index_i = '0;
    slot_i        = '0;
    for (int i = 0; i < QueueCount; i++) begin
      lst_nonempty[i] = 1'b0;
      lst_head[i]     = '0;
      lst_tail[i]     = '0;
    end
    for (int i = 0; i < SlotCount; i++) begin
      lst_next[i]    = '0;
      lst_prev[i]    = '0;
      lst_written[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].kind, directed_rows[i].queue, directed_rows[i].slot,
                directed_rows[i].typed, directed_rows[i].res);

    for (int w = 0; w < PhaseWords * PhaseCount; w++) begin
      if (w % PhaseWords == 0) begin
        // hold off until every outstanding word has come back
        in_valid_i <= 1'b0;
        while (list_results_q.size() != 0) @(posedge clk_i);
        case (w / PhaseWords)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 58; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 58; end
          default: begin idle_pct = 11; stall_pct = 11; end
        endcase
      end

      // walk the predicted lists to see which slots each queue holds
      foreach (owner[i]) owner[i] = -1;
      free_slots.delete();
      empty_qs.delete();
      busy_qs.delete();
      for (int qi = 0; qi < QueueCount; qi++) begin
        members[qi].delete();
        if (lst_nonempty[qi]) begin
          busy_qs.push_back(qi);
          cur   = int'(lst_head[qi]);
          steps = 0;
          while (cur < SlotCount && steps < SlotCount && owner[cur] < 0) begin
            owner[cur] = qi;
            members[qi].push_back(cur);
            cur = int'(lst_next[cur]);
            steps++;
          end
        end else begin
          empty_qs.push_back(qi);
        end
      end
      foreach (owner[i]) if (owner[i] < 0) free_slots.push_back(i);

      r    = $urandom_range(99);
      kind = KIND_NOP;
      qsel = QueueIdxW'($urandom);
      ssel = SlotW'($urandom);
      if (r < 40 && free_slots.size() > 0) begin
        kind = KIND_PUSH;
        ssel = SlotW'(free_slots[$urandom_range(free_slots.size() - 1)]);
      end else if (r < 85 && busy_qs.size() > 0) begin
        qsel = QueueIdxW'(busy_qs[$urandom_range(busy_qs.size() - 1)]);
        kind = KIND_DEQUEUE;
        if (r >= 62 && members[qsel].size() > 0) begin
          kind = KIND_REMOVE;
          ssel = SlotW'(members[qsel][$urandom_range(members[qsel].size() - 1)]);
        end
      end else begin
        case ($urandom_range(3))
          0: kind = KIND_NOP;
          1: begin
            kind = KIND_DEQUEUE;
            if (empty_qs.size() > 0) begin
              qsel = QueueIdxW'(empty_qs[$urandom_range(empty_qs.size() - 1)]);
            end
          end
          2: begin
            // remove with nothing to unlink: empty queue, or a slot held by no queue
            if (empty_qs.size() > 0) begin
              kind = KIND_REMOVE;
              qsel = QueueIdxW'(empty_qs[$urandom_range(empty_qs.size() - 1)]);
            end else if (free_slots.size() > 0) begin
              pick = free_slots[$urandom_range(free_slots.size() - 1)];
              if (lst_written[pick]) begin
                kind = KIND_REMOVE;
                ssel = SlotW'(pick);
              end
            end
          end
          default: begin
            // misuse: push a queued slot, or remove it, through a randomly picked queue
            if (busy_qs.size() > 0) begin
              pick = busy_qs[$urandom_range(busy_qs.size() - 1)];
              if (members[pick].size() > 0) begin
                ssel = SlotW'(members[pick][$urandom_range(members[pick].size() - 1)]);
                kind = ($urandom_range(1) == 0) ? KIND_PUSH : KIND_REMOVE;
              end
            end
          end
        endcase
      end
      send_word(kind, qsel, ssel, 1'b0, Untyped);
    end

    in_valid_i <= 1'b0;
    while (list_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
    if (list_results_q.size() != 0)
      report_mismatch($sformatf("%0d result words never came", list_results_q.size()));
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
